// ----- rtl/core/wpp_pkg.sv -----
`timescale 1ns / 1ps

package wpp_pkg;

	// payload widths
	localparam int REQ_W   = 2;
	localparam int POS_W   = 12;
	localparam int ANG_W   = 12;
	localparam int STEP_W  = 12;
	localparam int LIM_W   = 11;
	localparam int THR_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// default queue depth
	localparam int QUEUE_DEPTH_DEF = 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_GOTO = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEYPOINT_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RST = 12'd100;
	localparam logic [LIM_W-1:0]  LIM_RST  = 11'd1799;
	localparam logic [THR_W-1:0]  THR_RST  = 11'd10;

	// angle constants, tenths of a degree
	localparam logic [LIM_W-1:0] POS_MAX   = 11'd1799;
	localparam int               TURN      = 3600;
	localparam int               HALF_TURN = 1800;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [ANG_W-1:0]        ang_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FILL,
		ST_RD_WAIT,
		ST_RD_LOAD,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic goto_init;
		logic tick_eval;
		logic stop;
		logic fill_step;
		logic fill_finish;
		logic rd_load;
		logic res_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             fill_done;
		logic             tick_more;
	} dp_sts_t;

endpackage

// ----- rtl/core/wpp_if.sv -----
`timescale 1ns / 1ps

// request channel
interface wpp_req_if import wpp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	pos_t             target_pos;
	ang_t             feedback_angle;

	modport source(output valid, req_type, target_pos, feedback_angle, input ready);
	modport sink(input valid, req_type, target_pos, feedback_angle, output ready);
endinterface

// result channel
interface wpp_res_if import wpp_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd_valid;
	ang_t cmd_angle;
	logic arrived;
	logic busy_res;

	modport source(output valid, cmd_valid, cmd_angle, arrived, busy_res, input ready);
	modport sink(input valid, cmd_valid, cmd_angle, arrived, busy_res, output ready);
endinterface

// register write channel
interface wpp_cfg_if import wpp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/waypoint_position_planner_core.sv -----
`timescale 1ns / 1ps

// Waypoint planner for one axis. A goto item clamps its target to the
// position limit and builds a path of waypoints one keypoint step apart,
// through zero when the move changes side, keeping at most QUEUE_DEPTH of
// them; the first waypoint is issued as a single-turn angle. A tick item
// checks the feedback angle against the current waypoint and steps to the
// next one (or reports arrival) once the wrapped error is under the
// threshold. A stop item drops the active flag. Every item gives exactly
// one result. Items are handled one at a time. A goto walks its path in the
// fill state, one waypoint per cycle, since the queue has one write port,
// with one more fill step when the path runs through zero and the queue
// still has room there; a tick that moves on to a stored waypoint passes
// through a read wait and a read load state for one registered queue read.
// A pending result in the output register does not stop the next item from
// being taken, but that item waits for the register to empty before it
// finishes. Registers may be written at any time the block is idle; the
// register port is always ready.
module waypoint_position_planner_core import wpp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wpp_req_if.sink   req,
	wpp_res_if.source res,
	wpp_cfg_if.sink   cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	wpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// queue, position state and registers
	wpp_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req.req_type),
		.target_pos     (req.target_pos),
		.feedback_angle (req.feedback_angle),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.cmd_valid      (res.cmd_valid),
		.cmd_angle      (res.cmd_angle),
		.arrived        (res.arrived),
		.busy_res       (res.busy_res)
	);

endmodule

// ----- rtl/core/wpp_ctrl.sv -----
`timescale 1ns / 1ps

module wpp_ctrl import wpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				case (sts.req_type)
					REQ_GOTO: state_d = ST_FILL;
					REQ_TICK: state_d = sts.tick_more ? ST_RD_WAIT : ST_RESULT;
					default:  state_d = ST_RESULT;
				endcase
			end
			ST_FILL: begin
				if (sts.fill_done) state_d = ST_RESULT;
			end
			ST_RD_WAIT: state_d = ST_RD_LOAD;
			ST_RD_LOAD: state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.accept = in_valid;
			ST_EVAL: begin
				case (sts.req_type)
					REQ_GOTO: cmd.goto_init = 1'b1;
					REQ_TICK: cmd.tick_eval = 1'b1;
					REQ_STOP: cmd.stop      = 1'b1;
					default:  cmd = '0;
				endcase
			end
			ST_FILL: begin
				if (sts.fill_done) cmd.fill_finish = 1'b1;
				else cmd.fill_step = 1'b1;
			end
			ST_RD_LOAD: cmd.rd_load  = 1'b1;
			ST_RESULT:  cmd.res_load = slot_free;
			default:    cmd = '0;
		endcase
	end

	// output valid holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/wpp_dp.sv -----
`timescale 1ns / 1ps

module wpp_dp import wpp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [REQ_W-1:0]      req_type,
	input  pos_t                  target_pos,
	input  ang_t                  feedback_angle,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  cmd_valid,
	output ang_t                  cmd_angle,
	output logic                  arrived,
	output logic                  busy_res
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// clamp to +/- lim
	function automatic pos_t clamp_pos(pos_t p, logic [LIM_W-1:0] lim);
		pos_t l;
		pos_t r;
		l = pos_t'({1'b0, lim});
		r = p;
		if (r > l) r = l;
		if (r < -l) r = -l;
		return r;
	endfunction

	// signed position to single-turn angle
	function automatic ang_t to_single(pos_t p);
		logic signed [POS_W:0] w;
		w = {p[POS_W-1], p};
		if (p < 0) w = w + (POS_W+1)'(TURN);
		return w[ANG_W-1:0];
	endfunction

	// registers
	logic [STEP_W-1:0] step_q;
	logic [LIM_W-1:0]  lim_q;
	logic [THR_W-1:0]  thr_q;

	logic [REQ_W-1:0] req_q;
	pos_t             tgt_q;
	ang_t             fb_q;

	pos_t mem [QUEUE_DEPTH];
	pos_t rd_data_q;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] rdidx_q;
	pos_t          cur_q;
	pos_t          reached_q;
	logic          active_q;
	pos_t          p_q;
	pos_t          seg_to_q;
	pos_t          goal_q;
	logic          phase2_q;
	pos_t          first_q;
	logic          pend_cmd_q;
	logic          pend_arr_q;

	logic cmd_valid_q;
	ang_t cmd_angle_q;
	logic arrived_q;
	logic busy_q;

	// effective limit and clamped target
	logic [LIM_W-1:0] lim_eff;
	pos_t             tgt_clamp;
	logic             crossing;

	assign lim_eff   = (lim_q > POS_MAX) ? POS_MAX : lim_q;
	assign tgt_clamp = clamp_pos(tgt_q, lim_eff);
	assign crossing  = (reached_q > 0 && tgt_clamp < 0) || (reached_q < 0 && tgt_clamp > 0);

	// next waypoint of the current segment
	localparam int NW = POS_W + 2;
	logic [STEP_W-1:0]    step_eff;
	logic signed [NW-1:0] p_w, to_w, up_w, dn_w, nx_w;
	pos_t                 nx;
	logic                 seg_end;
	logic                 do_write;

	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign p_w      = NW'(p_q);
	assign to_w     = NW'(seg_to_q);
	assign up_w     = p_w + $signed({2'b00, step_eff});
	assign dn_w     = p_w - $signed({2'b00, step_eff});

	always_comb begin
		if (seg_to_q < p_q) nx_w = (dn_w < to_w) ? to_w : dn_w;
		else nx_w = (up_w > to_w) ? to_w : up_w;
	end

	assign nx       = nx_w[POS_W-1:0];
	assign seg_end  = (p_q == seg_to_q);
	assign do_write = cmd.fill_step && !seg_end;

	// wrapped error against the current waypoint
	localparam int DW = ANG_W + 2;
	logic signed [DW-1:0] diff, diff_w;
	logic [DW-1:0]        err;
	logic                 reached;
	logic [CW-1:0]        rdidx_inc;

	assign diff = $signed({2'b00, fb_q}) - $signed({2'b00, to_single(cur_q)});

	always_comb begin
		diff_w = diff;
		if (diff > DW'(HALF_TURN)) diff_w = diff - DW'(TURN);
		else if (diff < -DW'(HALF_TURN)) diff_w = diff + DW'(TURN);
	end

	assign err       = (diff_w < 0) ? DW'(-diff_w) : DW'(diff_w);
	assign reached   = err < DW'(thr_q);
	assign rdidx_inc = rdidx_q + CW'(1);

	assign sts.req_type  = req_q;
	assign sts.fill_done = (fill_q == DEPTH_C) || (seg_end && !phase2_q);
	assign sts.tick_more = active_q && reached && (rdidx_inc < fill_q);

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			lim_q  <= LIM_RST;
			thr_q  <= THR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEYPOINT_STEP:    step_q <= cfg_data;
				REG_POSITION_LIMIT:   lim_q  <= cfg_data[LIM_W-1:0];
				REG_ARRIVE_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				default:              step_q <= step_q;
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			tgt_q <= target_pos;
			fb_q  <= feedback_angle;
		end
	end

	// waypoint queue
	always_ff @(posedge clk) begin
		if (do_write) mem[fill_q[AW-1:0]] <= nx;
		rd_data_q <= mem[rdidx_q[AW-1:0]];
	end

	// segment walker payload
	always_ff @(posedge clk) begin
		if (cmd.goto_init) begin
			goal_q   <= tgt_clamp;
			p_q      <= reached_q;
			seg_to_q <= crossing ? '0 : tgt_clamp;
		end else if (cmd.fill_step) begin
			if (!seg_end) begin
				p_q <= nx;
				if (fill_q == '0) first_q <= nx;
			end else begin
				seg_to_q <= goal_q;
			end
		end
	end

	// planner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rdidx_q    <= '0;
			cur_q      <= '0;
			reached_q  <= '0;
			active_q   <= 1'b0;
			phase2_q   <= 1'b0;
			pend_cmd_q <= 1'b0;
			pend_arr_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pend_cmd_q <= 1'b0;
				pend_arr_q <= 1'b0;
			end
			if (cmd.goto_init) begin
				fill_q   <= '0;
				rdidx_q  <= '0;
				phase2_q <= crossing;
			end
			if (cmd.fill_step) begin
				if (!seg_end) fill_q <= fill_q + CW'(1);
				else phase2_q <= 1'b0;
			end
			if (cmd.fill_finish) begin
				active_q <= (fill_q != '0);
				if (fill_q != '0) begin
					cur_q      <= first_q;
					pend_cmd_q <= 1'b1;
				end
			end
			if (cmd.tick_eval) begin
				if (!active_q) begin
					pend_arr_q <= 1'b1;
				end else if (reached) begin
					reached_q <= cur_q;
					rdidx_q   <= rdidx_inc;
					if (rdidx_inc >= fill_q) begin
						active_q   <= 1'b0;
						pend_arr_q <= 1'b1;
					end
				end
			end
			if (cmd.stop) active_q <= 1'b0;
			if (cmd.rd_load) begin
				cur_q      <= rd_data_q;
				pend_cmd_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			cmd_valid_q <= pend_cmd_q;
			cmd_angle_q <= pend_cmd_q ? to_single(clamp_pos(cur_q, lim_eff)) : '0;
			arrived_q   <= pend_arr_q;
			busy_q      <= active_q;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd_angle = cmd_angle_q;
	assign arrived   = arrived_q;
	assign busy_res  = busy_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("queue fill count beyond depth");

	// a tick on an active planner always has a waypoint left
	a_active_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick_eval && active_q) |-> (rdidx_q < fill_q))
		else $error("active planner with no waypoint left");

	a_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_cmd_q && pend_arr_q))
		else $error("command and arrival pending together");

endmodule

// ----- tb/tb_waypoint_position_planner_core.sv -----
`timescale 1ns / 1ps

module tb_waypoint_position_planner_core;
	import wpp_pkg::*;

	localparam int QD          = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 12;
	localparam int DIR_ROWS    = 25;
	localparam int PHASES      = 7;

	// request code the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic cmd_valid;
		ang_t cmd_angle;
		logic arrived;
		logic busy_res;
	} plan_out_t;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		pos_t             target;
		ang_t             fb;
		logic             typed;
		plan_out_t        want;
	} dir_row_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] step;
		logic [CFG_DATA_W-1:0] lim;
		logic [CFG_DATA_W-1:0] thr;
		int                    n;
		bit                    calm;
		bit                    squeeze;
		bit                    rnd;
	} phase_t;

	localparam plan_out_t QUIET     = '0;
	localparam plan_out_t IDLE_TICK = '{1'b0, 12'd0, 1'b1, 1'b0};

	logic clk;
	logic arst_n;

	wpp_req_if req_ch();
	wpp_res_if res_ch();
	wpp_cfg_if cfg_ch();

	waypoint_position_planner_core #(.QUEUE_DEPTH(QD)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// directed items: extremes, every request code, path corner cases
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{REQ_TICK,   12'sd0,     12'd0,    1'b1, IDLE_TICK},
		'{REQ_STOP,   12'sd0,     12'd0,    1'b1, QUIET},
		'{REQ_UNUSED, 12'sd0,     12'd4095, 1'b1, QUIET},
		'{REQ_GOTO,   12'sd0,     12'd0,    1'b1, QUIET},
		'{REQ_GOTO,   12'sd2047,  12'd0,    1'b1, '{1'b1, 12'd100, 1'b0, 1'b1}},
		'{REQ_TICK,   12'sd0,     12'd4095, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd105,  1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd190,  1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd191,  1'b0, QUIET},
		'{REQ_GOTO,   12'sh800,   12'd0,    1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd100,  1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3599, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3500, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3400, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3300, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3200, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3100, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd3000, 1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd1234, 1'b1, IDLE_TICK},
		'{REQ_GOTO,   12'sd1799,  12'd0,    1'b0, QUIET},
		'{REQ_STOP,   12'sd0,     12'd0,    1'b1, QUIET},
		'{REQ_GOTO,   -12'sd1799, 12'd0,    1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd2900, 1'b0, QUIET},
		'{REQ_GOTO,   -12'sd650,  12'd0,    1'b0, QUIET},
		'{REQ_TICK,   12'sd0,     12'd2950, 1'b0, QUIET}
	};

	// register settings per random phase
	phase_t phase_tab [PHASES] = '{
		'{12'd100,  12'd1799, 12'd10,   130, 1'b0, 1'b1, 1'b0},
		'{12'd0,    12'hFFF,  12'd0,    60,  1'b0, 1'b0, 1'b0},
		'{12'd3598, 12'd0,    12'd1800, 110, 1'b0, 1'b0, 1'b0},
		'{12'hFFF,  12'd1799, 12'hFFF,  110, 1'b0, 1'b0, 1'b0},
		'{12'd1,    12'd900,  12'd1,    110, 1'b0, 1'b0, 1'b0},
		'{12'd0,    12'd0,    12'd0,    110, 1'b1, 1'b0, 1'b1},
		'{12'd0,    12'd0,    12'd0,    120, 1'b0, 1'b0, 1'b1}
	};

	// planner shadow state and registers
	int path_q [QD];
	int path_rd;
	int path_len;
	int wp_now;
	int reached_at;
	bit moving;
	int step_reg;
	int lim_reg;
	int thr_reg;

	plan_out_t plan_q [$];

	bit calm;
	bit hold_pending;
	int n_bad;
	int n_items;
	int n_gotos;
	int n_cmds;
	int n_arrive;
	int unsigned n_cycles;
	plan_out_t due;
	plan_out_t seen;

	function automatic int lim_eff();
		return (lim_reg > int'(POS_MAX)) ? int'(POS_MAX) : lim_reg;
	endfunction

	function automatic int clamp_to_lim(int p);
		int lim;
		lim = lim_eff();
		if (p > lim) p = lim;
		if (p < -lim) p = -lim;
		return p;
	endfunction

	// position to single-turn angle
	function automatic ang_t wrap_turn(int p);
		int s;
		s = p % TURN;
		if (s < 0) s += TURN;
		return ang_t'(s);
	endfunction

	// append waypoints from one position toward another, queue permitting
	function automatic void append_leg(int from, int to);
		int inc;
		int p;
		int nx;
		inc = (step_reg == 0) ? 1 : step_reg;
		p = from;
		if (to < from) inc = -inc;
		while (p != to && path_len < QD) begin
			nx = p + inc;
			if (inc > 0) begin
				if (nx > to) nx = to;
			end else if (nx < to) begin
				nx = to;
			end
			path_q[path_len] = nx;
			path_len++;
			p = nx;
		end
	endfunction

	// wrapped angle error against the threshold
	function automatic bit near_waypoint(int fb, int wp);
		int diff;
		diff = fb - int'(wrap_turn(wp));
		if (diff > HALF_TURN) diff -= TURN;
		else if (diff < -HALF_TURN) diff += TURN;
		if (diff < 0) diff = -diff;
		return diff < thr_reg;
	endfunction

	// advance the shadow planner by one item and return its result
	function automatic plan_out_t plan_item(logic [REQ_W-1:0] kind, pos_t tgt, ang_t fb);
		plan_out_t o;
		int dest;
		int from;
		o = '0;
		case (kind)
			REQ_GOTO: begin
				from = reached_at;
				dest = clamp_to_lim(int'(tgt));
				path_rd = 0;
				path_len = 0;
				if ((from > 0 && dest < 0) || (from < 0 && dest > 0)) begin
					append_leg(from, 0);
					append_leg(0, dest);
				end else begin
					append_leg(from, dest);
				end
				if (path_len == 0) begin
					moving = 1'b0;
				end else begin
					moving = 1'b1;
					wp_now = path_q[0];
					o.cmd_valid = 1'b1;
					o.cmd_angle = wrap_turn(clamp_to_lim(wp_now));
				end
			end
			REQ_TICK: begin
				if (!moving) begin
					o.arrived = 1'b1;
				end else if (near_waypoint(int'(fb), wp_now)) begin
					reached_at = wp_now;
					path_rd++;
					if (path_rd >= path_len) begin
						moving = 1'b0;
						o.arrived = 1'b1;
					end else begin
						wp_now = path_q[path_rd % QD];
						o.cmd_valid = 1'b1;
						o.cmd_angle = wrap_turn(clamp_to_lim(wp_now));
					end
				end
			end
			REQ_STOP: moving = 1'b0;
			default: ;
		endcase
		o.busy_res = moving;
		return o;
	endfunction

	// offer one item, wait for acceptance, queue its expected result
	task automatic send_item(input logic [REQ_W-1:0] kind, input pos_t tgt, input ang_t fb,
			input logic typed, input plan_out_t want);
		plan_out_t got;
		while (!calm && $urandom_range(0, 99) < 13) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= kind;
		req_ch.target_pos     <= tgt;
		req_ch.feedback_angle <= fb;
		do @(posedge clk); while (!req_ch.ready);
		got = plan_item(kind, tgt, fb);
		plan_q.push_back(typed ? want : got);
		n_items++;
		if (kind == REQ_GOTO) n_gotos++;
		if (got.cmd_valid) n_cmds++;
		if (kind == REQ_TICK && got.arrived) n_arrive++;
	endtask

	// random item, mostly ticks that track the current path, with some gotos, stops and unused codes
	task automatic pick_item(output logic [REQ_W-1:0] kind, output pos_t tgt, output ang_t fb);
		int roll;
		int sel;
		int lim;
		int span;
		int base;
		roll = $urandom_range(0, 99);
		tgt  = pos_t'($urandom_range(0, 4095));
		fb   = ang_t'($urandom_range(0, 4095));
		if (roll < 12) begin
			kind = REQ_GOTO;
			sel  = $urandom_range(0, 9);
			lim  = lim_eff();
			if (sel < 6) tgt = pos_t'(int'($urandom_range(0, 2 * lim)) - lim);
			else if (sel < 7) tgt = pos_t'(reached_at);
		end else if (roll < 16) begin
			kind = REQ_STOP;
		end else if (roll < 18) begin
			kind = REQ_UNUSED;
		end else begin
			kind = REQ_TICK;
			if (moving && $urandom_range(0, 9) < 8) begin
				span = (thr_reg > 40) ? 40 : thr_reg;
				base = int'(wrap_turn(wp_now)) + int'($urandom_range(0, 2 * span)) - span;
				base = int'(wrap_turn(base));
				// feedback past one turn now and then
				if ($urandom_range(0, 19) == 0 && base < 496) base += TURN;
				fb = ang_t'(base);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_KEYPOINT_STEP:    step_reg = int'(val);
			REG_POSITION_LIMIT:   lim_reg  = int'(val[LIM_W-1:0]);
			REG_ARRIVE_THRESHOLD: thr_reg  = int'(val[THR_W-1:0]);
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and let every outstanding result come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (plan_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		n_cycles = 0;
		while (n_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			n_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// result side ready, random stalls plus one long hold-off
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
			end
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen = '{res_ch.cmd_valid, res_ch.cmd_angle, res_ch.arrived, res_ch.busy_res};
			if (plan_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: v=%0d a=%0d arr=%0d busy=%0d",
						seen.cmd_valid, seen.cmd_angle, seen.arrived, seen.busy_res);
			end else begin
				due = plan_q.pop_front();
				if (seen.cmd_valid !== due.cmd_valid || seen.cmd_angle !== due.cmd_angle ||
						seen.arrived !== due.arrived || seen.busy_res !== due.busy_res) begin
					n_bad++;
					if (n_bad <= 10)
						$display("bad result: want v=%0d a=%0d arr=%0d busy=%0d, got v=%0d a=%0d arr=%0d busy=%0d",
							due.cmd_valid, due.cmd_angle, due.arrived, due.busy_res,
							seen.cmd_valid, seen.cmd_angle, seen.arrived, seen.busy_res);
				end
			end
		end
	end

	// stimulus
	initial begin
		int i;
		int k;
		logic [REQ_W-1:0] kind;
		pos_t tgt;
		ang_t fb;
		phase_t ph;

		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= REQ_GOTO;
		req_ch.target_pos     <= '0;
		req_ch.feedback_angle <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= REG_KEYPOINT_STEP;
		cfg_ch.data           <= '0;
		arst_n                <= 1'b0;

		path_rd      = 0;
		path_len     = 0;
		wp_now       = 0;
		reached_at   = 0;
		moving       = 1'b0;
		step_reg     = int'(STEP_RST);
		lim_reg      = int'(LIM_RST);
		thr_reg      = int'(THR_RST);
		calm         = 1'b0;
		hold_pending = 1'b0;
		n_bad        = 0;
		n_items      = 0;
		n_gotos      = 0;
		n_cmds       = 0;
		n_arrive     = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		for (i = 0; i < DIR_ROWS; i++)
			send_item(dir_tab[i].kind, dir_tab[i].target, dir_tab[i].fb,
				dir_tab[i].typed, dir_tab[i].want);

		// random phases, registers rewritten while idle
		for (i = 0; i < PHASES; i++) begin
			ph = phase_tab[i];
			settle();
			if (ph.rnd) begin
				ph.step = CFG_DATA_W'($urandom_range(1, 400));
				ph.lim  = CFG_DATA_W'($urandom_range(0, 1799));
				ph.thr  = CFG_DATA_W'($urandom_range(1, 60));
			end
			write_reg(REG_KEYPOINT_STEP, ph.step);
			write_reg(REG_POSITION_LIMIT, ph.lim);
			write_reg(REG_ARRIVE_THRESHOLD, ph.thr);
			calm = ph.calm;
			for (k = 0; k < ph.n; k++) begin
				if (ph.squeeze && k == 40) hold_pending = 1'b1;
				pick_item(kind, tgt, fb);
				send_item(kind, tgt, fb, 1'b0, QUIET);
			end
		end
		calm = 1'b0;
		settle();

		$display("%0d items (%0d goto) over %0d register settings in %0d cycles",
			n_items, n_gotos, PHASES + 1, n_cycles);
		$display("%0d position commands, %0d arrivals on tick, %0d bad results",
			n_cmds, n_arrive, n_bad);
		if (n_bad == 0 && plan_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
